// ===== hdl/ffa_pkg.sv =====
// Shared types and constants for the first-fit max-tree allocator.
`default_nettype none

package ffa_pkg;

    localparam int CAP_W = 30;

    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_DOWN,
        ST_UP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/ffa_node_ram.sv =====
// Tree node memory: one write port, two registered read ports.
`default_nettype none

module ffa_node_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 30
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] ra_addr,
    output logic      [DATA_W-1:0] ra_data,
    input  wire logic [ADDR_W-1:0] rb_addr,
    output logic      [DATA_W-1:0] rb_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/first_fit_max_tree_allocator.sv =====
// Top level of the first-fit allocator built on a max segment tree in memory.
`default_nettype none

// First-fit bin allocator. The free capacity of every bin lives in a heap-ordered
// max tree held in one dual-read-port memory of 2*LEAVES words, LEAVES being the
// smallest power of two not below N_BINS. After reset the block clears all
// 2*LEAVES words with in_stall high. A load beat (op 0) writes the bin's leaf
// and walks the maxima up to the root, one level a cycle. A request beat (op 1)
// reads the root, walks down one level a cycle reading both children, subtracts
// at the chosen leaf and walks back up, then hands the bin number to the output
// register once it is free; when no bin fits it goes from the root read straight
// to the output register with bin 0. One memory read per tree level in each
// direction paces both walks. Loads give no output beat; loads to bin 0 or
// above N_BINS are dropped. The output register lets the next item in while a
// finished result still waits under out_stall.
module first_fit_max_tree_allocator #(
    parameter int N_BINS = 1024,
    localparam int BIN_W = $clog2(N_BINS + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      op,
    input  wire logic [BIN_W-1:0]          bin_number,
    input  wire logic [ffa_pkg::CAP_W-1:0] amount,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic      [BIN_W-1:0]          bin_found
);

    import ffa_pkg::*;

    localparam int LEAF_W = $clog2(N_BINS);
    localparam int ADDR_W = LEAF_W + 1;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   node_reg, node_next;
    logic [CAP_W-1:0]    val_reg, val_next;
    logic [CAP_W-1:0]    amt_reg, amt_next;
    logic [BIN_W-1:0]    res_reg, res_next;
    logic                req_reg, req_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]    bin_found_reg, bin_found_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [CAP_W-1:0]    wdata;
    logic [ADDR_W-1:0]   ra_addr;
    logic [ADDR_W-1:0]   rb_addr;
    logic [CAP_W-1:0]    ra_data;
    logic [CAP_W-1:0]    rb_data;

    logic                accept;
    logic                bin_ok;
    logic [BIN_W-1:0]    bin_idx;
    logic [ADDR_W-1:0]   load_leaf;
    logic                go_right;
    logic [ADDR_W-1:0]   child;
    logic [CAP_W-1:0]    chosen;
    logic [ADDR_W-1:0]   parent;
    logic [CAP_W-1:0]    parent_max;
    logic                out_free;

    ffa_node_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CAP_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .ra_addr (ra_addr),
        .ra_data (ra_data),
        .rb_addr (rb_addr),
        .rb_data (rb_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign bin_found = bin_found_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign bin_ok    = (bin_number != '0) && (bin_number <= BIN_W'(N_BINS));
    assign bin_idx   = bin_number - BIN_W'(1);
    assign load_leaf = {1'b1, bin_idx[LEAF_W-1:0]};

    assign go_right   = (ra_data < amt_reg);
    assign child      = {node_reg[ADDR_W-2:0], go_right};
    assign chosen     = go_right ? rb_data : ra_data;
    assign parent     = node_reg >> 1;
    assign parent_max = (val_reg > ra_data) ? val_reg : ra_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        val_reg       <= val_next;
        amt_reg       <= amt_next;
        res_reg       <= res_next;
        req_reg       <= req_next;
        bin_found_reg <= bin_found_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        val_next       = val_reg;
        amt_next       = amt_reg;
        res_next       = res_reg;
        req_next       = req_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        bin_found_next = bin_found_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        ra_addr        = '0;
        rb_addr        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    amt_next = amount;
                    if (op_t'(op) == OP_REQUEST)
                    begin
                        req_next   = 1'b1;
                        ra_addr    = ADDR_W'(1);
                        state_next = ST_ROOT;
                    end
                    else if (bin_ok)
                    begin
                        // write the leaf and fetch its sibling for the climb
                        req_next   = 1'b0;
                        we         = 1'b1;
                        waddr      = load_leaf;
                        wdata      = amount;
                        ra_addr    = load_leaf ^ ADDR_W'(1);
                        node_next  = load_leaf;
                        val_next   = amount;
                        state_next = ST_UP;
                    end
                end
            end

            ST_ROOT:
            begin
                if (ra_data < amt_reg)
                begin
                    res_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    node_next  = ADDR_W'(1);
                    ra_addr    = ADDR_W'(2);
                    rb_addr    = ADDR_W'(3);
                    state_next = ST_DOWN;
                end
            end

            ST_DOWN:
            begin
                node_next = child;
                if (node_reg[ADDR_W-2])
                begin
                    // leaf reached: take the amount and start the climb
                    we         = 1'b1;
                    waddr      = child;
                    wdata      = chosen - amt_reg;
                    ra_addr    = child ^ ADDR_W'(1);
                    val_next   = chosen - amt_reg;
                    res_next   = BIN_W'(child[LEAF_W-1:0]) + BIN_W'(1);
                    state_next = ST_UP;
                end
                else
                begin
                    ra_addr = {child[ADDR_W-2:0], 1'b0};
                    rb_addr = {child[ADDR_W-2:0], 1'b1};
                end
            end

            ST_UP:
            begin
                we        = 1'b1;
                waddr     = parent;
                wdata     = parent_max;
                ra_addr   = parent ^ ADDR_W'(1);
                node_next = parent;
                val_next  = parent_max;
                if (parent == ADDR_W'(1))
                begin
                    state_next = req_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bin_found_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/tb_first_fit_max_tree_allocator.sv =====
// Self-checking testbench for the first-fit max-tree allocator with randomized handshakes.
module tb_first_fit_max_tree_allocator;

    import ffa_pkg::*;

    localparam int N_BINS     = 1024;
    localparam int BIN_W      = $clog2(N_BINS + 1);
    localparam int LEAVES     = 1 << $clog2(N_BINS);
    localparam int LEVELS     = $clog2(LEAVES);
    localparam int RAND_ITEMS = 1000;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_WAIT = 2 * LEVELS + 10;
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    typedef struct packed {
        op_t              op;
        logic [BIN_W-1:0] bin;
        logic [CAP_W-1:0] amount;
    } alloc_item_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic             op         = 1'b0;
    logic [BIN_W-1:0] bin_number = '0;
    logic [CAP_W-1:0] amount     = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [BIN_W-1:0] bin_found;

    alloc_item_t      pending_items[$];
    logic [BIN_W-1:0] expected_bins[$];
    logic [CAP_W-1:0] cap_tree[0:2*LEAVES-1];

    alloc_item_t      launch_item;
    alloc_item_t      seen_item;
    logic [BIN_W-1:0] want_bin;
    logic             in_taken = 1'b0;
    logic             quiet    = 1'b0;
    int               gap_left   = 0;
    int               stall_left = 0;
    bit               failed     = 1'b0;

    first_fit_max_tree_allocator #(
        .N_BINS(N_BINS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .bin_number (bin_number),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_found  (bin_found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Recompute the maxima on the path from a node to the root.
    task automatic bubble_up(input int leaf);
        int n;
        n = leaf >> 1;
        while (n > 0)
        begin
            cap_tree[n] = (cap_tree[2*n] > cap_tree[2*n+1]) ? cap_tree[2*n] : cap_tree[2*n+1];
            n = n >> 1;
        end
    endtask

    // Update the tree copy for one accepted beat and queue the bin it should return.
    task automatic allocate_or_load(input alloc_item_t it);
        int n;
        if (it.op == OP_LOAD)
        begin
            if (it.bin >= 1 && it.bin <= N_BINS)
            begin
                n = LEAVES + int'(it.bin) - 1;
                cap_tree[n] = it.amount;
                bubble_up(n);
            end
        end
        else if (cap_tree[1] < it.amount)
        begin
            expected_bins.push_back('0);
        end
        else
        begin
            n = 1;
            while (n < LEAVES)
                n = (cap_tree[2*n] >= it.amount) ? 2 * n : 2 * n + 1;
            cap_tree[n] = cap_tree[n] - it.amount;
            bubble_up(n);
            expected_bins.push_back(BIN_W'(n - LEAVES + 1));
        end
    endtask

    task automatic add_item(input op_t o, input int bin, input logic [CAP_W-1:0] amt);
        alloc_item_t it;
        it.op     = o;
        it.bin    = BIN_W'(bin);
        it.amount = amt;
        pending_items.push_back(it);
    endtask

    // Random capacity spread over magnitudes of lo_w to hi_w bits.
    function automatic logic [CAP_W-1:0] rand_capacity(input int lo_w, input int hi_w);
        int w;
        w = $urandom_range(hi_w, lo_w);
        if ($urandom_range(0, 49) == 0)
            return CAP_MAX;
        return CAP_W'($urandom_range(0, (1 << w) - 1));
    endfunction

    // Input driver: one beat at a time, random gaps, payload held while stalled.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                launch_item = pending_items.pop_front();
                op         <= launch_item.op;
                bin_number <= launch_item.bin;
                amount     <= launch_item.amount;
                in_valid   <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall in random bursts, dropped for the tail of the run.
    always @(negedge clk)
    begin
        if (quiet)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predict on every accepted input beat, check every accepted output beat.
    always @(posedge clk)
    begin
        quiet <= (pending_items.size() <= QUIET_TAIL);
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                seen_item.op     = op_t'(op);
                seen_item.bin    = bin_number;
                seen_item.amount = amount;
                allocate_or_load(seen_item);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_bins.size() == 0)
                begin
                    $error("bin_found: expected none, actual %0d", bin_found);
                    failed = 1'b1;
                end
                else
                begin
                    want_bin = expected_bins.pop_front();
                    if (bin_found !== want_bin)
                    begin
                        $error("bin_found: expected %0d, actual %0d", want_bin, bin_found);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        int pick;
        int bin;
        foreach (cap_tree[k])
            cap_tree[k] = '0;

        // Empty tree: a zero request lands on bin 1, anything else misses.
        add_item(OP_REQUEST, 0, '0);
        add_item(OP_REQUEST, 2047, 1);
        // Out-of-range loads are dropped.
        add_item(OP_LOAD, 0, 500);
        add_item(OP_LOAD, N_BINS + 1, 500);
        add_item(OP_LOAD, 2047, CAP_MAX);
        add_item(OP_REQUEST, 5, 1);
        // Full capacity on bin 1 and a smaller load on bin N_BINS, the two ends of the bin range.
        add_item(OP_LOAD, 1, CAP_MAX);
        add_item(OP_REQUEST, 0, CAP_MAX);
        add_item(OP_REQUEST, 0, 1);
        add_item(OP_LOAD, N_BINS, 100);
        add_item(OP_REQUEST, 0, 100);
        add_item(OP_REQUEST, 0, '0);
        // Reload replaces rather than adds.
        add_item(OP_LOAD, 3, 50);
        add_item(OP_LOAD, 3, 20);
        add_item(OP_REQUEST, 0, 30);
        add_item(OP_REQUEST, 0, 20);
        // Walk across the middle of the tree.
        add_item(OP_LOAD, 512, 7);
        add_item(OP_LOAD, 513, 9);
        add_item(OP_REQUEST, 0, 8);
        add_item(OP_REQUEST, 0, 7);
        add_item(OP_REQUEST, 0, 1);
        // Leftmost wins among equal fits.
        add_item(OP_LOAD, 2, 1);
        add_item(OP_LOAD, 1, 1);
        add_item(OP_REQUEST, 0, 1);
        add_item(OP_LOAD, N_BINS, CAP_MAX);
        add_item(OP_REQUEST, 0, CAP_MAX);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 40)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    bin = $urandom_range(0, 1) ? 0 : $urandom_range(N_BINS + 1, 2**BIN_W - 1);
                else if (pick < 8)
                    bin = $urandom_range(1, 16);    // crowd the left edge
                else
                    bin = $urandom_range(1, N_BINS);
                add_item(OP_LOAD, bin, rand_capacity(8, 30));
            end
            else
            begin
                add_item(OP_REQUEST, $urandom_range(0, 2**BIN_W - 1), rand_capacity(0, 24));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_bins.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
